// ===== rtl/pbk_pkg.sv =====
`timescale 1ns / 1ps

package pbk_pkg;

  // Field widths fixed by the item formats.
  localparam int FRAME_W  = 32;
  localparam int SAMPLE_W = 32;
  localparam int PEAK_W   = 32;
  localparam int RB_W     = 10;

  // Default size of the peak overview and of the front-to-back queue.
  localparam int NUM_BUCKETS_DEF = 1024;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Item mode codes.
  localparam logic MODE_ACCUM = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Front end sequencer states.
  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_DIV,
    F_PUSH
  } front_state_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_LOOKUP
  } back_state_t;

  // Status that the back end reports to the front end.
  typedef struct packed {
    logic clear_done;
  } back_status_t;

endpackage

// ===== rtl/pbk_if.sv =====
`timescale 1ns / 1ps

// Sample and read request channel.
interface pbk_in_if import pbk_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [FRAME_W-1:0]         frame_index;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [RB_W-1:0]            read_bucket;

  modport source (output valid, mode, frame_index, sample_value, read_bucket, input ready);
  modport sink   (input valid, mode, frame_index, sample_value, read_bucket, output ready);
endinterface

// Peak result channel.
interface pbk_out_if import pbk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PEAK_W-1:0] peak_magnitude;
  logic [RB_W-1:0]   bucket_number;

  modport source (output valid, peak_magnitude, bucket_number, input ready);
  modport sink   (input valid, peak_magnitude, bucket_number, output ready);
endinterface

// Configuration write channel for the recording length.
interface pbk_cfg_if import pbk_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] total_frames;

  modport source (output valid, total_frames, input ready);
  modport sink   (input valid, total_frames, output ready);
endinterface

// ===== rtl/pbk_queue.sv =====
`timescale 1ns / 1ps

module pbk_queue import pbk_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTRW-1:0]  wr_ptr_r;
  logic [PTRW-1:0]  rd_ptr_r;
  logic [CNTW-1:0]  count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNTW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = store_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count, wrapping at the depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/pbk_front.sv =====
`timescale 1ns / 1ps

module pbk_front import pbk_pkg::*; #(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int OPW         = 2 + $clog2(NUM_BUCKETS) + PEAK_W + RB_W
) (
  input  logic               clk,
  input  logic               rst_n,
  pbk_in_if.sink             in_ch,
  input  logic [FRAME_W-1:0] total_frames,
  input  back_status_t       back_status,
  output logic               op_valid,
  input  logic               op_ready,
  output logic [OPW-1:0]     op_data
);

  localparam int AW   = $clog2(NUM_BUCKETS);
  localparam int NBW  = $clog2(NUM_BUCKETS + 1);
  localparam int PW   = FRAME_W + NBW;
  localparam int CNTW = $clog2(AW + 1);
  localparam int CW   = ((AW > RB_W) ? AW : RB_W) + 1;

  front_state_t       state_r;
  front_state_t       state_nxt;
  logic               accept;

  logic               mode_r;
  logic [FRAME_W-1:0] frame_r;
  logic [PEAK_W-1:0]  mag_r;
  logic [RB_W-1:0]    rb_r;
  logic               hit_r;
  logic               sat_r;
  logic [FRAME_W-1:0] rem_r;
  logic [AW-1:0]      low_r;
  logic [AW-1:0]      quot_r;
  logic [CNTW-1:0]    cnt_r;

  logic [FRAME_W-1:0] divisor;
  logic [PEAK_W-1:0]  sample_u;
  logic [PEAK_W-1:0]  mag_in;
  logic [CW-1:0]      rb_c;
  logic [PW-1:0]      product;
  logic [FRAME_W:0]   trial;
  logic               take;
  logic [FRAME_W-1:0] rem_nxt;
  logic [AW-1:0]      bucket;

  // A zero length counts as one frame.
  assign divisor = (total_frames == '0) ? FRAME_W'(1) : total_frames;

  // Two's complement magnitude; the most negative sample gives 2^31.
  assign sample_u = PEAK_W'(unsigned'(in_ch.sample_value));
  assign mag_in   = sample_u[PEAK_W-1] ? (PEAK_W'(0) - sample_u) : sample_u;

  assign rb_c    = CW'(in_ch.read_bucket);
  assign product = PW'(frame_r) * PW'(NUM_BUCKETS);

  // One restoring division step: the remainder always stays below the divisor.
  assign trial   = {rem_r, low_r[AW-1]};
  assign take    = (trial >= {1'b0, divisor});
  assign rem_nxt = take ? FRAME_W'(trial - {1'b0, divisor}) : trial[FRAME_W-1:0];

  assign bucket  = sat_r ? AW'(NUM_BUCKETS - 1) : quot_r;
  assign op_data = {mode_r, hit_r, bucket, mag_r, rb_r};

  // Sequencer: accept, multiply, divide one quotient bit a cycle, hand off.
  always_comb begin
    state_nxt   = state_r;
    accept      = 1'b0;
    in_ch.ready = 1'b0;
    op_valid    = 1'b0;
    case (state_r)
      F_IDLE: begin
        in_ch.ready = back_status.clear_done;
        accept      = in_ch.valid && back_status.clear_done;
        if (accept) begin
          state_nxt = (in_ch.mode == MODE_READ) ? F_PUSH : F_MUL;
        end
      end
      F_MUL: begin
        state_nxt = sat_r ? F_PUSH : F_DIV;
      end
      F_DIV: begin
        if (cnt_r == CNTW'(AW - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        op_valid = 1'b1;
        if (op_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item capture and divider datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_ch.mode;
      frame_r <= in_ch.frame_index;
      mag_r   <= mag_in;
      rb_r    <= in_ch.read_bucket;
      hit_r   <= (rb_c < CW'(NUM_BUCKETS));
      quot_r  <= rb_c[AW-1:0];
      // A frame at or past the recording length saturates to the last bucket.
      sat_r   <= (in_ch.mode == MODE_ACCUM) && (in_ch.frame_index >= divisor);
    end
    if (state_r == F_MUL) begin
      rem_r <= FRAME_W'(product >> AW);
      low_r <= product[AW-1:0];
      cnt_r <= '0;
    end
    if (state_r == F_DIV) begin
      rem_r  <= rem_nxt;
      low_r  <= low_r << 1;
      quot_r <= (quot_r << 1) | AW'(take);
      cnt_r  <= cnt_r + 1'b1;
    end
  end

endmodule

// ===== rtl/pbk_back.sv =====
`timescale 1ns / 1ps

module pbk_back import pbk_pkg::*; #(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int OPW         = 2 + $clog2(NUM_BUCKETS) + PEAK_W + RB_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           op_valid,
  output logic           op_ready,
  input  logic [OPW-1:0] op_data,
  output back_status_t   back_status,
  pbk_out_if.source      out_ch
);

  localparam int AW = $clog2(NUM_BUCKETS);

  back_state_t       state_r;
  back_state_t       state_nxt;

  logic [PEAK_W-1:0] mem_r [NUM_BUCKETS];
  logic [PEAK_W-1:0] rdata_r;
  logic              rd_en;
  logic              mem_we;
  logic [AW-1:0]     waddr;
  logic [PEAK_W-1:0] wdata;

  logic [AW-1:0]     clr_addr_r;

  logic              op_mode;
  logic              op_hit;
  logic [AW-1:0]     op_addr;
  logic [PEAK_W-1:0] op_mag;
  logic [RB_W-1:0]   op_rb;

  logic              cur_mode_r;
  logic              cur_hit_r;
  logic [AW-1:0]     cur_addr_r;
  logic [PEAK_W-1:0] cur_mag_r;
  logic [RB_W-1:0]   cur_rb_r;

  logic              out_valid_r;
  logic [PEAK_W-1:0] out_peak_r;
  logic [RB_W-1:0]   out_bkt_r;
  logic              out_load;

  assign {op_mode, op_hit, op_addr, op_mag, op_rb} = op_data;

  assign back_status.clear_done = (state_r != B_CLEAR);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.peak_magnitude = out_peak_r;
  assign out_ch.bucket_number  = out_bkt_r;

  // Sequencer: clearing sweep after reset, then read-modify-write per transaction.
  always_comb begin
    state_nxt = state_r;
    op_ready  = 1'b0;
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    waddr     = cur_addr_r;
    wdata     = '0;
    out_load  = 1'b0;
    case (state_r)
      B_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_addr_r;
        if (clr_addr_r == AW'(NUM_BUCKETS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        // Take the next operation only once the result slot is empty.
        op_ready = !out_valid_r;
        if (op_valid && !out_valid_r) begin
          rd_en     = 1'b1;
          state_nxt = B_LOOKUP;
        end
      end
      B_LOOKUP: begin
        state_nxt = B_IDLE;
        if (cur_mode_r == MODE_ACCUM) begin
          mem_we = (cur_mag_r > rdata_r);
          wdata  = cur_mag_r;
        end else begin
          // A read clears the bucket it returns; an out-of-range read touches nothing.
          mem_we   = cur_hit_r;
          out_load = 1'b1;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // Peak store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem_r[op_addr];
    end
  end

  // Operation held for the lookup cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_mode_r <= op_mode;
      cur_hit_r  <= op_hit;
      cur_addr_r <= op_addr;
      cur_mag_r  <= op_mag;
      cur_rb_r   <= op_rb;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_peak_r <= cur_hit_r ? rdata_r : '0;
      out_bkt_r  <= cur_rb_r;
    end
  end

endmodule

// ===== rtl/waveform_peak_bucketizer_top.sv =====
`timescale 1ns / 1ps

// Channel   Port    Role    Payload
// -------   ------  ------  ---------------------------------------------------
// input     in_ch   sink    mode, frame_index, sample_value, read_bucket
// result    out_ch  source  peak_magnitude, bucket_number
// config    cfg_ch  sink    total_frames
//
// An accumulate transaction goes through accept, multiply, divide and hand-off in the front
// end, the divider giving one quotient bit a cycle; a frame at or past the length skips
// the divide. A read transaction goes from accept straight to hand-off. The back end reads
// and then writes the peak store for each operation, behind a 2-entry queue.
// After reset the store is swept clear with in_ch.ready low.
// A result waiting on out_ch holds the back end; the front end runs on until the queue fills.

module waveform_peak_bucketizer_top import pbk_pkg::*; #(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pbk_in_if.sink    in_ch,
  pbk_out_if.source out_ch,
  pbk_cfg_if.sink   cfg_ch
);

  localparam int AW  = $clog2(NUM_BUCKETS);
  localparam int OPW = 2 + AW + PEAK_W + RB_W;

  logic [FRAME_W-1:0] total_frames_r;
  back_status_t       back_status;
  logic               fq_valid;
  logic               fq_ready;
  logic [OPW-1:0]     fq_data;
  logic               qb_valid;
  logic               qb_ready;
  logic [OPW-1:0]     qb_data;

  // Recording length register.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_frames_r <= FRAME_W'(1);
    end else if (cfg_ch.valid) begin
      total_frames_r <= cfg_ch.total_frames;
    end
  end

  pbk_front #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .OPW         (OPW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .total_frames (total_frames_r),
    .back_status  (back_status),
    .op_valid     (fq_valid),
    .op_ready     (fq_ready),
    .op_data      (fq_data)
  );

  pbk_queue #(
    .WIDTH (OPW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  pbk_back #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .OPW         (OPW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .op_valid    (qb_valid),
    .op_ready    (qb_ready),
    .op_data     (qb_data),
    .back_status (back_status),
    .out_ch      (out_ch)
  );

endmodule

// ===== dv/tb_waveform_peak_bucketizer_top.sv =====
`timescale 1ns / 1ps

module tb_waveform_peak_bucketizer_top;
  import pbk_pkg::*;

  localparam int N_BUCKETS    = NUM_BUCKETS_DEF;
  // Front end divider, queue and store access, with margin.
  localparam int QUIET_CYCLES = 48;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_ITEMS  = 112;

  typedef struct packed {
    logic [PEAK_W-1:0] peak_magnitude;
    logic [RB_W-1:0]   bucket_number;
  } peak_result_t;

  // Tracks the peak store and the recording length, and checks each peak readout.
  class peak_store_scoreboard;
    logic [PEAK_W-1:0]  bucket_peaks [N_BUCKETS];
    logic [FRAME_W-1:0] total_frames;
    peak_result_t       expected_peaks [$];
    int errors;
    int n_samples;
    int n_reads;
    int n_checked;
    int n_nonzero;

    function new();
      total_frames = 1;
      foreach (bucket_peaks[i]) bucket_peaks[i] = '0;
      errors    = 0;
      n_samples = 0;
      n_reads   = 0;
      n_checked = 0;
      n_nonzero = 0;
    endfunction

    // Scale the frame by the bucket count, divide by the length and saturate.
    function logic [RB_W-1:0] bucket_of_frame(logic [FRAME_W-1:0] frame);
      logic [63:0] divisor;
      logic [63:0] quotient;
      divisor  = (total_frames == 0) ? 64'd1 : {32'd0, total_frames};
      quotient = ({32'd0, frame} * 64'(N_BUCKETS)) / divisor;
      if (quotient > 64'(N_BUCKETS - 1)) quotient = 64'(N_BUCKETS - 1);
      return quotient[RB_W-1:0];
    endfunction

    // The most negative sample maps to 2^31, which still fits in 32 bits.
    function logic [PEAK_W-1:0] sample_magnitude(logic [SAMPLE_W-1:0] raw);
      return raw[SAMPLE_W-1] ? (~raw + 32'd1) : raw;
    endfunction

    function void note_transaction(logic mode, logic [FRAME_W-1:0] frame,
                                   logic [SAMPLE_W-1:0] sample, logic [RB_W-1:0] rb);
      peak_result_t      res;
      logic [RB_W-1:0]   b;
      logic [PEAK_W-1:0] m;
      if (mode == MODE_ACCUM) begin
        b = bucket_of_frame(frame);
        m = sample_magnitude(sample);
        if (m > bucket_peaks[b]) bucket_peaks[b] = m;
        n_samples++;
      end else begin
        res.bucket_number  = rb;
        res.peak_magnitude = '0;
        if (int'(rb) < N_BUCKETS) begin
          res.peak_magnitude = bucket_peaks[rb];
          bucket_peaks[rb]   = '0;
        end
        expected_peaks.push_back(res);
        n_reads++;
      end
    endfunction

    function void check_peak(logic [PEAK_W-1:0] peak, logic [RB_W-1:0] bucket);
      peak_result_t exp_res;
      if (expected_peaks.size() == 0) begin
        $error("unexpected result: bucket_number %0d peak_magnitude %0d", bucket, peak);
        errors++;
        return;
      end
      exp_res = expected_peaks.pop_front();
      n_checked++;
      if (exp_res.peak_magnitude != 0) n_nonzero++;
      if (peak !== exp_res.peak_magnitude) begin
        $error("peak_magnitude: expected %0d, actual %0d", exp_res.peak_magnitude, peak);
        errors++;
      end
      if (bucket !== exp_res.bucket_number) begin
        $error("bucket_number: expected %0d, actual %0d", exp_res.bucket_number, bucket);
        errors++;
      end
    endfunction

    function int pending();
      return expected_peaks.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pbk_in_if  in_if ();
  pbk_out_if out_if ();
  pbk_cfg_if cfg_if ();

  peak_store_scoreboard sb = new();

  bit              no_idle       = 1'b0;
  bit              hold_results  = 1'b0;
  logic [RB_W-1:0] last_bucket   = '0;
  int              n_lengths     = 0;
  int              cycle_count   = 0;

  waveform_peak_bucketizer_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Check every peak transaction that leaves the block.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_peak(out_if.peak_magnitude, out_if.bucket_number);
  end

  // Result side: random stalls per transaction, and a long hold when requested.
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready) && !hold_results);
    end
  end

  // Offer one transaction after a random gap and hold it until accepted.
  task automatic send_item(input logic mode, input logic [FRAME_W-1:0] frame,
                           input logic [SAMPLE_W-1:0] sample, input logic [RB_W-1:0] rb);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.mode         <= mode;
    in_if.frame_index  <= frame;
    in_if.sample_value <= sample;
    in_if.read_bucket  <= rb;
    do @(posedge clk); while (!in_if.ready);
    sb.note_transaction(mode, frame, sample, rb);
  endtask

  // Stop offering until every pending peak has come back.
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  // Let the block go idle, then write the recording length.
  task automatic set_total_frames(input logic [FRAME_W-1:0] value);
    wait_for_results();
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_if.valid        <= 1'b1;
    cfg_if.total_frames <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.total_frames = value;
    n_lengths++;
  endtask

  // Mostly samples inside the recording, some near its end and some anywhere;
  // reads mostly target the bucket most recently written.
  task automatic random_item(input int read_pct);
    logic [FRAME_W-1:0]  frame;
    logic [SAMPLE_W-1:0] sample;
    logic [RB_W-1:0]     rb;
    int pick;
    frame  = $urandom;
    sample = $urandom;
    rb     = RB_W'($urandom_range(0, N_BUCKETS - 1));
    if ($urandom_range(0, 99) < read_pct) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) rb = last_bucket;
      else if (pick == 6) rb = '0;
      else if (pick == 7) rb = RB_W'(N_BUCKETS - 1);
      send_item(MODE_READ, frame, sample, rb);
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 14)
        frame = (sb.total_frames > 1) ? $urandom_range(0, sb.total_frames - 1) : '0;
      else if (pick < 17)
        frame = sb.total_frames + FRAME_W'($urandom_range(0, 4)) - 32'd2;
      case ($urandom_range(0, 9))
        0: sample = 32'h8000_0000;
        1: sample = 32'h7FFF_FFFF;
        2: sample = 32'h0000_0000;
        3: sample = 32'hFFFF_FFFF;
        4, 5: sample = SAMPLE_W'($urandom_range(0, 4095)) - 32'd2048;
        default: ;
      endcase
      last_bucket = sb.bucket_of_frame(frame);
      send_item(MODE_ACCUM, frame, sample, rb);
    end
  endtask

  initial begin
    int phase;
    int i;
    logic [FRAME_W-1:0] length;

    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.mode          <= MODE_ACCUM;
    in_if.frame_index   <= '0;
    in_if.sample_value  <= '0;
    in_if.read_bucket   <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.total_frames <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset length of one frame: frame zero lands in the first bucket, all
    // others saturate into the last one.
    send_item(MODE_ACCUM, 32'd0, 32'h8000_0000, '0);
    send_item(MODE_ACCUM, 32'd0, 32'h7FFF_FFFF, '0);
    send_item(MODE_ACCUM, 32'd1, 32'hFFFF_FFFF, '0);
    send_item(MODE_ACCUM, 32'hFFFF_FFFF, 32'h7FFF_FFFF, '0);
    send_item(MODE_ACCUM, 32'd5, 32'h0000_0000, 10'h3FF);
    // Reads ignore the frame and sample fields and clear what they return.
    send_item(MODE_READ, 32'hFFFF_FFFF, 32'h8000_0000, 10'd0);
    send_item(MODE_READ, 32'd0, 32'd0, 10'd0);
    send_item(MODE_READ, 32'h5555_5555, 32'hAAAA_AAAA, 10'h3FF);
    send_item(MODE_READ, 32'd0, 32'd0, 10'd512);

    // A zero length behaves like a length of one.
    set_total_frames(32'd0);
    send_item(MODE_ACCUM, 32'd0, 32'd123, '0);
    send_item(MODE_ACCUM, 32'd7, 32'hFFFF_FFFB, '0);
    send_item(MODE_READ, 32'd0, 32'd0, 10'd0);
    send_item(MODE_READ, 32'd0, 32'd0, 10'h3FF);

    // Longest recording: the last frame still saturates into the last bucket.
    set_total_frames(32'hFFFF_FFFF);
    send_item(MODE_ACCUM, 32'hFFFF_FFFF, 32'h8000_0001, '0);
    send_item(MODE_ACCUM, 32'h7FFF_FFFF, 32'h0000_0001, '0);
    send_item(MODE_ACCUM, 32'h7FFF_FFFF, 32'hFFFF_FFFE, '0);
    send_item(MODE_READ, 32'd0, 32'd0, 10'd511);
    send_item(MODE_READ, 32'd0, 32'd0, 10'h3FF);

    // Random phases, each with its own recording length.
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: length = 32'd1024;
        1: length = 32'd0;
        2: length = $urandom_range(1, 3000);
        3: length = 32'hFFFF_FFFF;
        4: length = 32'd1;
        5: length = $urandom;
        6: length = $urandom_range(1000, 200000);
        default: length = 32'd48000;
      endcase
      set_total_frames(length);
      no_idle = (phase == 2 || phase == 6);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // Hold the result side while reads keep coming, so the input stalls.
        if (phase == 3 && i == PHASE_ITEMS / 3) begin
          hold_results = 1'b1;
          repeat (40) random_item(70);
        end
        if (phase == 5 && i == PHASE_ITEMS / 2) wait_for_results();
        random_item(30);
      end
    end

    wait_for_results();
    repeat (QUIET_CYCLES) @(posedge clk);

    $display("Covered %0d sample and %0d read transactions over %0d recording lengths.",
             sb.n_samples, sb.n_reads, n_lengths);
    $display("Checked %0d peak readouts, %0d of them nonzero.", sb.n_checked, sb.n_nonzero);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
